// File: sv/ycbcr422_to_rgb_converter_assert.svh
// Assertion macros shared by the converter modules.
// Each macro takes a label, clock, reset, antecedent, consequent and message.
`ifndef YCBCR422_TO_RGB_CONVERTER_ASSERT_SVH
`define YCBCR422_TO_RGB_CONVERTER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication.
`define YC2RGB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define YC2RGB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define YC2RGB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define YC2RGB_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: sv/yc2rgb_pkg.sv
`default_nettype none

package yc2rgb_pkg;

   // Beat on the byte input
   typedef struct packed {
      logic [7:0] stream_byte;
   } req_type;

   // Pixel result beat
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // One pixel's worth of components, queued between front and back
   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] cb;
      logic [7:0] cr;
   } yuv_type;

   // Pixel queue geometry
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // BT.601 coefficients scaled by 256
   localparam logic [8:0] COEF_Y    = 9'd298;
   localparam logic [8:0] COEF_CR_R = 9'd409;
   localparam logic [6:0] COEF_CB_G = 7'd100;
   localparam logic [7:0] COEF_CR_G = 8'd208;
   localparam logic [9:0] COEF_CB_B = 10'd516;

   // Sum width and offsets with the rounding half already folded in
   localparam int unsigned SUM_W = 20;
   localparam logic signed [SUM_W-1:0] BIAS_R = -20'sd56940;
   localparam logic signed [SUM_W-1:0] BIAS_G = 20'sd34835;
   localparam logic signed [SUM_W-1:0] BIAS_B = -20'sd70742;

endpackage

`default_nettype wire

// File: sv/yc2rgb_stream_if.sv
`default_nettype none

interface yc2rgb_stream_if #(
   parameter type payload_type = logic [7:0]
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: sv/yc2rgb_front.sv
`default_nettype none

module yc2rgb_front (
   input  logic             clock,
   input  logic             reset,
   yc2rgb_stream_if.sink    req,
   yc2rgb_stream_if.source  pix
);

`include "ycbcr422_to_rgb_converter_assert.svh"

   localparam logic [1:0] PHASE_CB = 2'd0;
   localparam logic [1:0] PHASE_Y0 = 2'd1;
   localparam logic [1:0] PHASE_CR = 2'd2;
   localparam logic [1:0] PHASE_Y1 = 2'd3;

   logic [1:0]          phase_ff, phase_in;
   logic [7:0]          luma_ff, luma_in;
   logic [7:0]          cb_ff, cb_in;
   logic [7:0]          cr_ff, cr_in;
   logic                emit;
   logic                accept;
   logic [7:0]          in_byte;
   yc2rgb_pkg::yuv_type pix_data;

   // Cr and Y1 beats each produce one pixel
   assign emit    = (phase_ff == PHASE_CR) || (phase_ff == PHASE_Y1);
   assign in_byte = req.payload.stream_byte;

   // Only stall on beats that need queue space
   assign req.ready   = !emit || pix.ready;
   assign pix.valid   = req.valid && emit;
   assign pix.payload = pix_data;
   assign accept      = req.valid && req.ready;

   // Sort the byte by phase and assemble the pixel components
   always_comb begin
      phase_in = phase_ff;
      luma_in  = luma_ff;
      cb_in    = cb_ff;
      cr_in    = cr_ff;
      pix_data = '{luma: luma_ff, cb: cb_ff, cr: cr_ff};
      case (phase_ff)
         PHASE_CB: begin
            cb_in = in_byte;
         end
         PHASE_Y0: begin
            luma_in = in_byte;
         end
         PHASE_CR: begin
            cr_in       = in_byte;
            pix_data.cr = in_byte;
         end
         PHASE_Y1: begin
            luma_in       = in_byte;
            pix_data.luma = in_byte;
         end
         default: begin
            cb_in = cb_ff;
         end
      endcase
      if (accept) begin
         phase_in = phase_ff + 2'd1;
      end else begin
         luma_in = luma_ff;
         cb_in   = cb_ff;
         cr_in   = cr_ff;
      end
   end

   // Advance the phase
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_CB;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // Hold the component bytes
   always_ff @(posedge clock) begin
      luma_ff <= luma_in;
      cb_ff   <= cb_in;
      cr_ff   <= cr_in;
   end

   `YC2RGB_ASSERT_NEXT(a_phase_step, clock, reset, accept, phase_ff == $past(phase_ff) + 2'd1, "phase did not advance on an accepted beat")
   `YC2RGB_ASSERT_IMPLY(a_emit_only_pixel_phases, clock, reset, pix.valid, req.valid && (phase_ff == PHASE_CR || phase_ff == PHASE_Y1), "pixel pushed outside Cr or Y1 phase")

endmodule

`default_nettype wire

// File: sv/yc2rgb_fifo.sv
`default_nettype none

module yc2rgb_fifo (
   input  logic             clock,
   input  logic             reset,
   yc2rgb_stream_if.sink    q_in,
   yc2rgb_stream_if.source  q_out
);

`include "ycbcr422_to_rgb_converter_assert.svh"

   localparam int unsigned DEPTH = yc2rgb_pkg::QUEUE_DEPTH;
   localparam int unsigned AW    = yc2rgb_pkg::QUEUE_AW;
   localparam int unsigned CW    = yc2rgb_pkg::QUEUE_CW;

   yc2rgb_pkg::yuv_type slot_ff [DEPTH];
   logic [AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                push;
   logic                pop;

   assign q_in.ready    = count_ff != CW'(DEPTH);
   assign q_out.valid   = count_ff != '0;
   assign q_out.payload = slot_ff[rd_ptr_ff];
   assign push          = q_in.valid && q_in.ready;
   assign pop           = q_out.valid && q_out.ready;

   // Advance pointers and track fill
   always_comb begin
      wr_ptr_in = push ? AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = CW'(count_ff + 1'b1);
         2'b01:   count_in = CW'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed beat
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= q_in.payload;
      end
   end

   `YC2RGB_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH), "queue count beyond depth")
   `YC2RGB_ASSERT_NEXT(a_count_track, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue count missed a push")

endmodule

`default_nettype wire

// File: sv/yc2rgb_back.sv
`default_nettype none

module yc2rgb_back (
   input  logic             clock,
   input  logic             reset,
   yc2rgb_stream_if.sink    pix,
   yc2rgb_stream_if.source  rsp
);

`include "ycbcr422_to_rgb_converter_assert.svh"

   localparam int unsigned SW = yc2rgb_pkg::SUM_W;

   // Products kept between the multiply and the sum stage
   typedef struct packed {
      logic [16:0] luma;
      logic [16:0] red_cr;
      logic [16:0] green_c;
      logic [17:0] blue_cb;
   } prod_type;

   logic                adv_a, adv_b;
   logic                a_valid_ff, a_valid_in;
   logic                out_valid_ff, out_valid_in;
   prod_type            prod_ff, prod_in;
   yc2rgb_pkg::rgb_type rgb_ff, rgb_in;
   logic signed [SW-1:0] sum_r, sum_g, sum_b;

   // Round by the folded half, drop the fraction and clamp to a byte
   function automatic logic [7:0] round_clamp(input logic signed [SW-1:0] sum);
      logic [7:0] res;
      if (sum[SW-1]) begin
         res = 8'd0;
      end else if (|sum[SW-2:16]) begin
         res = 8'hFF;
      end else begin
         res = sum[15:8];
      end
      return res;
   endfunction

   // Stall handling: each stage moves when the one after it has room
   assign adv_b     = !out_valid_ff || rsp.ready;
   assign adv_a     = !a_valid_ff || adv_b;
   assign pix.ready = adv_a;

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = rgb_ff;

   // Multiply stage
   always_comb begin
      prod_in.luma    = 17'(yc2rgb_pkg::COEF_Y) * 17'(pix.payload.luma);
      prod_in.red_cr  = 17'(yc2rgb_pkg::COEF_CR_R) * 17'(pix.payload.cr);
      prod_in.green_c = 17'(yc2rgb_pkg::COEF_CB_G) * 17'(pix.payload.cb)
                      + 17'(yc2rgb_pkg::COEF_CR_G) * 17'(pix.payload.cr);
      prod_in.blue_cb = 18'(yc2rgb_pkg::COEF_CB_B) * 18'(pix.payload.cb);
      if (!(adv_a && pix.valid)) begin
         prod_in = prod_ff;
      end
      a_valid_in = adv_a ? pix.valid : a_valid_ff;
   end

   // Sum, round and clamp stage
   always_comb begin
      sum_r = $signed({3'b000, prod_ff.luma}) + $signed({3'b000, prod_ff.red_cr})
            + yc2rgb_pkg::BIAS_R;
      sum_g = $signed({3'b000, prod_ff.luma}) - $signed({3'b000, prod_ff.green_c})
            + yc2rgb_pkg::BIAS_G;
      sum_b = $signed({3'b000, prod_ff.luma}) + $signed({2'b00, prod_ff.blue_cb})
            + yc2rgb_pkg::BIAS_B;
      rgb_in = rgb_ff;
      if (adv_b && a_valid_ff) begin
         rgb_in.red   = round_clamp(sum_r);
         rgb_in.green = round_clamp(sum_g);
         rgb_in.blue  = round_clamp(sum_b);
      end
      out_valid_in = adv_b ? a_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rgb_ff  <= rgb_in;
   end

   `YC2RGB_ASSERT_NEXT(a_stage_hold, clock, reset, a_valid_ff && !adv_b, a_valid_ff && $stable(prod_ff), "blocked product stage lost its beat")
   `YC2RGB_ASSERT_IMPLY(a_stall_cause, clock, reset, !pix.ready, a_valid_ff && out_valid_ff && !rsp.ready, "back end stalled with room to spare")

endmodule

`default_nettype wire

// File: sv/ycbcr422_to_rgb_converter.sv
// Path: a pixel reaches rsp_if through the queue slot, the product register and the output register.
// Throughput: one byte beat per cycle, sustained while rsp_if stays ready; two pixels per four beats.
// The multiply and sum/clamp stages are each registered; a two-entry queue sits before them.
// Reset (synchronous, active high) sets the byte phase to Cb and empties queue and pipeline.
// Component bytes and pipeline data are not reset.
`default_nettype none

module ycbcr422_to_rgb_converter (
   input  logic             clock,
   input  logic             reset,
   yc2rgb_stream_if.sink    req_if,
   yc2rgb_stream_if.source  rsp_if
);

   yc2rgb_stream_if #(.payload_type(yc2rgb_pkg::yuv_type)) pix_push ();
   yc2rgb_stream_if #(.payload_type(yc2rgb_pkg::yuv_type)) pix_pop ();

   // Sort bytes into components
   yc2rgb_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .pix   (pix_push)
   );

   // Queue assembled pixels
   yc2rgb_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .q_in  (pix_push),
      .q_out (pix_pop)
   );

   // Convert to RGB
   yc2rgb_back u_back (
      .clock (clock),
      .reset (reset),
      .pix   (pix_pop),
      .rsp   (rsp_if)
   );

endmodule

`default_nettype wire

// File: test/ycbcr422_to_rgb_converter_tb.sv
module ycbcr422_to_rgb_converter_tb;

   // Position of a byte inside its Cb Y0 Cr Y1 group
   typedef enum logic [1:0] {
      SLOT_CB = 2'd0,
      SLOT_Y0 = 2'd1,
      SLOT_CR = 2'd2,
      SLOT_Y1 = 2'd3
   } slot_type;

   // Directed beat: byte, whether the pixel is written out here, and that pixel
   typedef struct packed {
      logic [7:0]          stream_byte;
      logic                spelled;
      yc2rgb_pkg::rgb_type pixel;
   } stim_row_type;

   // BT.601 in 8.8 fixed point
   localparam int K_LUMA   = 298;
   localparam int K_CR_RED = 409;
   localparam int K_CB_GRN = 100;
   localparam int K_CR_GRN = 208;
   localparam int K_CB_BLU = 516;
   localparam int OFS_RED  = -57068;
   localparam int OFS_GRN  = 34707;
   localparam int OFS_BLU  = -70870;

   localparam int NUM_ROWS     = 24;
   localparam int RANDOM_BEATS = 1326;
   localparam int QUIET_FROM   = RANDOM_BEATS - 150;
   localparam int LONG_HOLD    = 120;
   localparam int REPORT_MAX   = 10;

   // Black/white pair, all-zero group, all-ones group, then extremes and bit toggles
   localparam stim_row_type STIM_ROWS [NUM_ROWS] = '{
      '{8'd128, 1'b0, 24'h000000}, '{8'd16,  1'b0, 24'h000000},
      '{8'd128, 1'b1, 24'h000000}, '{8'd235, 1'b1, 24'hFFFFFF},
      '{8'd0,   1'b0, 24'h000000}, '{8'd0,   1'b0, 24'h000000},
      '{8'd0,   1'b1, 24'h008800}, '{8'd0,   1'b1, 24'h008800},
      '{8'd255, 1'b0, 24'h000000}, '{8'd255, 1'b0, 24'h000000},
      '{8'd255, 1'b1, 24'hFF7EFF}, '{8'd255, 1'b1, 24'hFF7EFF},
      '{8'd0,   1'b0, 24'h000000}, '{8'd255, 1'b0, 24'h000000},
      '{8'd0,   1'b0, 24'h000000}, '{8'd0,   1'b0, 24'h000000},
      '{8'd255, 1'b0, 24'h000000}, '{8'd0,   1'b0, 24'h000000},
      '{8'd255, 1'b0, 24'h000000}, '{8'd255, 1'b0, 24'h000000},
      '{8'h55,  1'b0, 24'h000000}, '{8'hAA,  1'b0, 24'h000000},
      '{8'hAA,  1'b0, 24'h000000}, '{8'h55,  1'b0, 24'h000000}
   };

   logic clock;
   logic reset;

   yc2rgb_stream_if #(.payload_type(yc2rgb_pkg::req_type)) req_if ();
   yc2rgb_stream_if #(.payload_type(yc2rgb_pkg::rgb_type)) rsp_if ();

   ycbcr422_to_rgb_converter u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Side info that travels with the byte on the input
   logic                note_spelled;
   yc2rgb_pkg::rgb_type note_pixel;

   // Model state
   slot_type   next_slot = SLOT_CB;
   logic [7:0] held_luma = '0;
   logic [7:0] held_cb   = '0;
   logic [7:0] held_cr   = '0;

   yc2rgb_pkg::rgb_type pending_pixels [$];

   // Knobs set by the source process; the sink reads quiet, hold_asked and snk_idle_pct
   bit quiet       = 1'b0;
   bit hold_asked  = 1'b0;
   int src_idle_pct = 0;
   int snk_idle_pct = 0;

   int error_count   = 0;
   int bytes_in      = 0;
   int pixels_seen   = 0;
   int backpressure  = 0;
   int clamped_comps = 0;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] round_clamp(input int sum);
      int t;
      t = sum + 128;
      if (t < 0) return 8'd0;
      if ((t >>> 8) > 255) return 8'hFF;
      return t[15:8];
   endfunction

   function automatic yc2rgb_pkg::rgb_type convert_pixel(input logic [7:0] y,
                                                         input logic [7:0] cb,
                                                         input logic [7:0] cr);
      int ys, b, r;
      yc2rgb_pkg::rgb_type px;
      ys = K_LUMA * int'(y);
      b  = int'(cb);
      r  = int'(cr);
      px.red   = round_clamp(ys + K_CR_RED * r + OFS_RED);
      px.green = round_clamp(ys - K_CB_GRN * b - K_CR_GRN * r + OFS_GRN);
      px.blue  = round_clamp(ys + K_CB_BLU * b + OFS_BLU);
      return px;
   endfunction

   // Sort one byte into the held components; report a pixel after Cr and Y1
   task automatic unpack_byte(input logic [7:0] b, output bit made,
                              output yc2rgb_pkg::rgb_type px);
      made = 1'b0;
      px   = '0;
      case (next_slot)
         SLOT_CB: held_cb = b;
         SLOT_Y0: held_luma = b;
         SLOT_CR: begin
            held_cr = b;
            made = 1'b1;
            px = convert_pixel(held_luma, held_cb, held_cr);
         end
         default: begin
            held_luma = b;
            made = 1'b1;
            px = convert_pixel(held_luma, held_cb, held_cr);
         end
      endcase
      next_slot = slot_type'(next_slot + 2'd1);
   endtask

   task automatic flag_error(input string what, input yc2rgb_pkg::rgb_type want,
                             input yc2rgb_pkg::rgb_type got);
      error_count++;
      if (error_count <= REPORT_MAX)
         $display("ERROR @%0t: %s: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                  $time, what, want.red, want.green, want.blue,
                  got.red, got.green, got.blue);
   endtask

   function automatic int count_rails(input yc2rgb_pkg::rgb_type px);
      return int'(px.red == 8'd0 || px.red == 8'hFF) +
             int'(px.green == 8'd0 || px.green == 8'hFF) +
             int'(px.blue == 8'd0 || px.blue == 8'hFF);
   endfunction

   // Predict on each accepted byte beat, check each accepted pixel beat
   always @(posedge clock) begin : scoreboard
      bit                  made;
      yc2rgb_pkg::rgb_type px;
      yc2rgb_pkg::rgb_type want;
      yc2rgb_pkg::rgb_type got;
      if (!reset) begin
         if (req_if.valid && !req_if.ready) backpressure++;
         if (req_if.valid && req_if.ready) begin
            bytes_in++;
            unpack_byte(req_if.payload.stream_byte, made, px);
            if (made) pending_pixels.push_back(note_spelled ? note_pixel : px);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            pixels_seen++;
            clamped_comps += count_rails(got);
            if (pending_pixels.size() == 0) begin
               flag_error("pixel with nothing pending", '0, got);
            end else begin
               want = pending_pixels.pop_front();
               if (got.red !== want.red)     flag_error("red mismatch", want, got);
               if (got.green !== want.green) flag_error("green mismatch", want, got);
               if (got.blue !== want.blue)   flag_error("blue mismatch", want, got);
            end
         end
      end
   end

   // Bias the random bytes toward the range ends and the nominal levels
   function automatic logic [7:0] pick_byte();
      logic [7:0] corners [6] = '{8'd0, 8'd255, 8'd16, 8'd235, 8'd128, 8'd240};
      if ($urandom_range(0, 99) < 15) return corners[$urandom_range(0, 5)];
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_beat(input logic [7:0] b, input logic spelled,
                            input yc2rgb_pkg::rgb_type px);
      if (!quiet && $urandom_range(0, 99) < src_idle_pct) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid               <= 1'b1;
      req_if.payload.stream_byte <= b;
      note_spelled               <= spelled;
      note_pixel                 <= px;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain_pixels();
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // Byte source: directed rows, then random bytes in segments of varying idle rate
   initial begin : byte_source
      int idle_opts [3];
      idle_opts      = '{0, 10, 35};
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      note_spelled   = 1'b0;
      note_pixel     = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      src_idle_pct = 20;
      snk_idle_pct = 20;
      foreach (STIM_ROWS[i])
         send_beat(STIM_ROWS[i].stream_byte, STIM_ROWS[i].spelled, STIM_ROWS[i].pixel);

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i % 150 == 0) begin
            src_idle_pct = idle_opts[$urandom_range(0, 2)];
            snk_idle_pct = idle_opts[$urandom_range(0, 2)];
         end
         // Stall the output long enough to back up the queue into the input
         if (i == 400) hold_asked = 1'b1;
         // Let everything drain before going on
         if (i == 800) begin
            @(negedge clock);
            req_if.valid <= 1'b0;
            drain_pixels();
         end
         if (i == QUIET_FROM) quiet = 1'b1;
         send_beat(pick_byte(), 1'b0, '0);
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      drain_pixels();
      repeat (8) @(posedge clock);

      $display("Checked %0d pixels from %0d byte beats; %0d input stall cycles,",
               pixels_seen, bytes_in, backpressure);
      $display("%0d components at a clamp rail, %0d pixels left over.",
               clamped_comps, pending_pixels.size());
      if (error_count == 0 && pending_pixels.size() == 0)
         $display("ycbcr422_to_rgb_converter regression: pass");
      else
         $display("ycbcr422_to_rgb_converter regression: fail");
      $finish;
   end

   // Pixel sink: random stall bursts, one long hold on request, none at the end
   initial begin : pixel_sink
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked) begin
            hold_asked = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 99) < snk_idle_pct) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Watchdog
   initial begin : watchdog
      #2000000;
      $display("Timeout with %0d pixels pending", pending_pixels.size());
      $display("ycbcr422_to_rgb_converter regression: fail");
      $finish;
   end

endmodule
